// ===== sv/aapr_pkg.sv =====
package aapr_pkg;

   // Angle resolution: 2^ANGLE_BITS steps make one full turn.
   localparam int ANGLE_BITS = 16;
   localparam int REM_BITS   = ANGLE_BITS - 2;

   // Fixed-point formats of the datapath.
   localparam int DIR_FRAC  = 14;
   localparam int TRIG_FRAC = 20;

   // pi/2 in Q1.30 and one in Q1.30.
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [30:0] Q30_ONE     = 31'd1073741824;

   // Latency of the trig unit from its angle register to its output registers.
   localparam int TRIG_LAT = 21;

   // Taylor denominators of the Horner chains, highest-order term first.
   localparam int SIN_STEPS = 5;
   localparam int COS_STEPS = 6;
   localparam int SIN_DIV [SIN_STEPS] = '{110, 72, 42, 20, 6};
   localparam int COS_DIV [COS_STEPS] = '{132, 90, 56, 30, 12, 2};

   // Configuration register indexes.
   localparam logic [2:0] CSR_POINT_X = 3'd0;
   localparam logic [2:0] CSR_POINT_Y = 3'd1;
   localparam logic [2:0] CSR_POINT_Z = 3'd2;
   localparam logic [2:0] CSR_DIR_X   = 3'd3;
   localparam logic [2:0] CSR_DIR_Y   = 3'd4;
   localparam logic [2:0] CSR_DIR_Z   = 3'd5;

   localparam logic signed [15:0] DIR_Y_RESET = 16'sd16384;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [15:0]        angle;
   } req_type;

   typedef struct packed {
      logic signed [31:0] rotated_x;
      logic signed [31:0] rotated_y;
      logic signed [31:0] rotated_z;
   } rsp_type;

   // Shift right by n with rounding half away from zero.
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int unsigned n);
      logic signed [63:0] half;
      half = 64'sd1 <<< (n - 1);
      if (v >= 0) begin
         return (v + half) >>> n;
      end
      return -(((-v) + half) >>> n);
   endfunction

endpackage

// ===== sv/aapr_hstep.sv =====
// One Horner step: h_out = 1.0 - floor(floor(x2 * h_in / 2^30) / DIVISOR), in Q2.30.
// The division by the constant is a reciprocal multiply followed by one correction.
module aapr_hstep #(
   parameter int DIVISOR = 2
) (
   input  logic               clock,
   input  logic [31:0]        x2_in,
   input  logic [30:0]        h_in,
   output logic [31:0]        x2_out,
   output logic signed [32:0] h_out
);

   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIVISOR);

   logic [31:0]        p_ff, p2_ff, q0_ff;
   logic [31:0]        x2a_ff, x2b_ff, x2c_ff;
   logic signed [32:0] h_ff;
   logic [31:0]        rem_in, q_in;

   always_comb begin
      rem_in = p2_ff - 32'(q0_ff * 32'(DIVISOR));
      q_in   = (rem_in >= 32'(DIVISOR)) ? q0_ff + 32'd1 : q0_ff;
   end

   always_ff @(posedge clock) begin
      p_ff   <= 32'((64'(x2_in) * 64'(h_in)) >> 30);
      q0_ff  <= 32'((64'(p_ff) * 64'(RECIP)) >> 32);
      p2_ff  <= p_ff;
      h_ff   <= $signed({2'b00, aapr_pkg::Q30_ONE}) - $signed({1'b0, q_in});
      x2a_ff <= x2_in;
      x2b_ff <= x2a_ff;
      x2c_ff <= x2b_ff;
   end

   assign x2_out = x2c_ff;
   assign h_out  = h_ff;

endmodule

// ===== sv/aapr_trig.sv =====
// Pipelined sine and cosine of a binary angle, Q.20 outputs, plus 1 - cos.
module aapr_trig (
   input  logic                            clock,
   input  logic [aapr_pkg::ANGLE_BITS-1:0] angle,
   output logic signed [22:0]              sin_q20,
   output logic signed [22:0]              cos_q20,
   output logic signed [22:0]              omc_q20
);

   localparam int NS = aapr_pkg::SIN_STEPS;
   localparam int NC = aapr_pkg::COS_STEPS;

   logic [30:0]        x1_ff, xb_ff;
   logic [31:0]        x2_ff;
   logic [1:0]         quad1_ff;
   logic [30:0]        x_line_ff [15];
   logic [1:0]         q_line_ff [19];
   logic [30:0]        s_ff, s_d1_ff, s_d2_ff;
   logic signed [22:0] sin_ff, cos_ff, omc_ff;

   logic [31:0]        sx2 [NS+1];
   logic signed [32:0] sh  [NS+1];
   logic [31:0]        cx2 [NC+1];
   logic signed [32:0] ch  [NC+1];

   logic [21:0]        s_rnd_in, c_rnd_in;
   logic [30:0]        c_clamp_in;
   logic signed [22:0] s_pos_in, c_pos_in, sin_in, cos_in;

   assign sx2[0] = x2_ff;
   assign sh[0]  = $signed({2'b00, aapr_pkg::Q30_ONE});
   assign cx2[0] = x2_ff;
   assign ch[0]  = $signed({2'b00, aapr_pkg::Q30_ONE});

   for (genvar i = 0; i < NS; i++) begin : g_sin
      aapr_hstep #(.DIVISOR(aapr_pkg::SIN_DIV[i])) u_step (
         .clock  (clock),
         .x2_in  (sx2[i]),
         .h_in   (sh[i][30:0]),
         .x2_out (sx2[i+1]),
         .h_out  (sh[i+1])
      );
   end

   for (genvar i = 0; i < NC; i++) begin : g_cos
      aapr_hstep #(.DIVISOR(aapr_pkg::COS_DIV[i])) u_step (
         .clock  (clock),
         .x2_in  (cx2[i]),
         .h_in   (ch[i][30:0]),
         .x2_out (cx2[i+1]),
         .h_out  (ch[i+1])
      );
   end

   always_comb begin
      // The last cosine step can dip slightly below zero near a right angle.
      c_clamp_in = ch[NC][32] ? 31'd0 : ch[NC][30:0];
      s_rnd_in   = 22'((32'(s_d2_ff) + 32'd512) >> 10);
      c_rnd_in   = 22'((32'(c_clamp_in) + 32'd512) >> 10);
      s_pos_in   = $signed({1'b0, s_rnd_in});
      c_pos_in   = $signed({1'b0, c_rnd_in});
      case (q_line_ff[18])
         2'd0: begin
            sin_in = s_pos_in;
            cos_in = c_pos_in;
         end
         2'd1: begin
            sin_in = c_pos_in;
            cos_in = -s_pos_in;
         end
         2'd2: begin
            sin_in = -s_pos_in;
            cos_in = -c_pos_in;
         end
         default: begin
            sin_in = -c_pos_in;
            cos_in = s_pos_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x1_ff    <= 31'((45'(angle[aapr_pkg::REM_BITS-1:0]) * 45'(aapr_pkg::HALF_PI_Q30))
                      >> aapr_pkg::REM_BITS);
      quad1_ff <= angle[aapr_pkg::ANGLE_BITS-1 -: 2];
      x2_ff    <= 32'((62'(x1_ff) * 62'(x1_ff)) >> 30);
      xb_ff    <= x1_ff;
      x_line_ff[0] <= xb_ff;
      for (int i = 1; i < 15; i++) begin
         x_line_ff[i] <= x_line_ff[i-1];
      end
      q_line_ff[0] <= quad1_ff;
      for (int i = 1; i < 19; i++) begin
         q_line_ff[i] <= q_line_ff[i-1];
      end
      s_ff    <= 31'((62'(x_line_ff[14]) * 62'(sh[NS][30:0])) >> 30);
      s_d1_ff <= s_ff;
      s_d2_ff <= s_d1_ff;
      sin_ff  <= sin_in;
      cos_ff  <= cos_in;
      omc_ff  <= 23'sd1048576 - cos_in;
   end

   assign sin_q20 = sin_ff;
   assign cos_q20 = cos_ff;
   assign omc_q20 = omc_ff;

endmodule

// ===== sv/axis_angle_point_rotation_unit.sv =====
// Rotation of a 3D point about an arbitrary axis (Rodrigues form):
//    P' = A + D*cos + (k x D)*sin + k*(k.D)*(1 - cos),  D = P - A.
// The axis point A and the Q2.14 axis direction k are written through the
// csr_ port (csr_we, csr_index, csr_wdata); write them only while no
// transaction is in flight. The direction is used as written, unnormalized.
// An input transaction is taken on each clock edge with start high; busy is
// always low, so a new point may enter on every cycle. Each point carries its
// own angle as a fraction of a full turn.
// A result appears on rsp_data with rsp_strobe high for exactly one cycle,
// after the input, geometry, trig, product, sum and result registers. One
// result per cycle is sustained; the latency is set by the sine/cosine unit,
// whose Horner chains take three stages per term (multiply, reciprocal
// multiply, fixup). The receiver cannot stall, so nothing is ever held back.
// Reset clears the pipeline valid bits and sets A = 0 and k = (0, 1, 0).
module axis_angle_point_rotation_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  aapr_pkg::req_type req_data,
   output logic              rsp_strobe,
   output aapr_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   localparam int GEO_DLY = aapr_pkg::TRIG_LAT - 5;
   localparam int OUT_LAT = aapr_pkg::TRIG_LAT + 3;

   // Configuration.
   logic signed [31:0] axis_point_ff [3];
   logic signed [15:0] axis_dir_ff   [3];

   // Input register and valid line.
   aapr_pkg::req_type in_ff;
   logic              valid_ff [OUT_LAT+1];
   logic              accept;

   // Geometry path.
   logic signed [32:0] d1_ff [3];
   logic signed [48:0] prod_ff [3][3];
   logic signed [32:0] d2_ff [3];
   logic signed [36:0] dot_ff;
   logic signed [35:0] cr3_ff [3];
   logic signed [32:0] d3_ff [3];
   logic signed [52:0] ep_ff [3];
   logic signed [35:0] cr4_ff [3];
   logic signed [32:0] d4_ff [3];
   logic signed [38:0] e5_ff [3];
   logic signed [35:0] cr5_ff [3];
   logic signed [32:0] d5_ff [3];
   logic signed [32:0] d_line_ff  [GEO_DLY][3];
   logic signed [35:0] cr_line_ff [GEO_DLY][3];
   logic signed [38:0] e_line_ff  [GEO_DLY][3];

   // Combination stages.
   logic signed [55:0] tc_ff [3];
   logic signed [58:0] ts_ff [3];
   logic signed [61:0] to_ff [3];
   logic signed [43:0] sum_ff [3];
   logic signed [31:0] res_ff [3];

   logic signed [22:0] sin_q20, cos_q20, omc_q20;

   logic signed [36:0] dot_in;
   logic signed [35:0] cr_in  [3];
   logic signed [38:0] e_in   [3];
   logic signed [43:0] sum_in [3];
   logic signed [44:0] tot_in [3];
   logic signed [31:0] res_in [3];

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   aapr_trig u_trig (
      .clock   (clock),
      .angle   (in_ff.angle[aapr_pkg::ANGLE_BITS-1:0]),
      .sin_q20 (sin_q20),
      .cos_q20 (cos_q20),
      .omc_q20 (omc_q20)
   );

   // Configuration writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_point_ff[0] <= '0;
         axis_point_ff[1] <= '0;
         axis_point_ff[2] <= '0;
         axis_dir_ff[0]   <= '0;
         axis_dir_ff[1]   <= aapr_pkg::DIR_Y_RESET;
         axis_dir_ff[2]   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            aapr_pkg::CSR_POINT_X: axis_point_ff[0] <= $signed(csr_wdata);
            aapr_pkg::CSR_POINT_Y: axis_point_ff[1] <= $signed(csr_wdata);
            aapr_pkg::CSR_POINT_Z: axis_point_ff[2] <= $signed(csr_wdata);
            aapr_pkg::CSR_DIR_X:   axis_dir_ff[0]   <= $signed(csr_wdata[15:0]);
            aapr_pkg::CSR_DIR_Y:   axis_dir_ff[1]   <= $signed(csr_wdata[15:0]);
            aapr_pkg::CSR_DIR_Z:   axis_dir_ff[2]   <= $signed(csr_wdata[15:0]);
            default: ;
         endcase
      end
   end

   // Valid bits travel alongside the data through every stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= OUT_LAT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= accept;
         for (int i = 1; i <= OUT_LAT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_comb begin
      // Dot product k.D and cross product k x D, each rounded back to Q.0, the scale of D.
      dot_in = 37'(aapr_pkg::rnd_shift(64'(prod_ff[0][0]) + 64'(prod_ff[1][1])
                                       + 64'(prod_ff[2][2]), aapr_pkg::DIR_FRAC));
      cr_in[0] = 36'(aapr_pkg::rnd_shift(64'(prod_ff[1][2]) - 64'(prod_ff[2][1]),
                                         aapr_pkg::DIR_FRAC));
      cr_in[1] = 36'(aapr_pkg::rnd_shift(64'(prod_ff[2][0]) - 64'(prod_ff[0][2]),
                                         aapr_pkg::DIR_FRAC));
      cr_in[2] = 36'(aapr_pkg::rnd_shift(64'(prod_ff[0][1]) - 64'(prod_ff[1][0]),
                                         aapr_pkg::DIR_FRAC));
      for (int i = 0; i < 3; i++) begin
         e_in[i]   = 39'(aapr_pkg::rnd_shift(64'(ep_ff[i]), aapr_pkg::DIR_FRAC));
         sum_in[i] = 44'(aapr_pkg::rnd_shift(64'(tc_ff[i]) + 64'(ts_ff[i]) + 64'(to_ff[i]),
                                             aapr_pkg::TRIG_FRAC));
         tot_in[i] = 45'(sum_ff[i]) + 45'(axis_point_ff[i]);
         if (tot_in[i] > 45'sd2147483647) begin
            res_in[i] = 32'sh7fffffff;
         end else if (tot_in[i] < -45'sd2147483648) begin
            res_in[i] = 32'sh80000000;
         end else begin
            res_in[i] = 32'(tot_in[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= req_data;

      d1_ff[0] <= 33'(in_ff.point_x) - 33'(axis_point_ff[0]);
      d1_ff[1] <= 33'(in_ff.point_y) - 33'(axis_point_ff[1]);
      d1_ff[2] <= 33'(in_ff.point_z) - 33'(axis_point_ff[2]);

      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 3; j++) begin
            prod_ff[k][j] <= 49'(axis_dir_ff[k]) * 49'(d1_ff[j]);
         end
         d2_ff[k]  <= d1_ff[k];
         d3_ff[k]  <= d2_ff[k];
         cr3_ff[k] <= cr_in[k];
         ep_ff[k]  <= 53'(axis_dir_ff[k]) * 53'(dot_ff);
         d4_ff[k]  <= d3_ff[k];
         cr4_ff[k] <= cr3_ff[k];
         e5_ff[k]  <= e_in[k];
         d5_ff[k]  <= d4_ff[k];
         cr5_ff[k] <= cr4_ff[k];
      end
      dot_ff <= dot_in;

      // Hold the geometry until the matching sine and cosine arrive.
      for (int k = 0; k < 3; k++) begin
         d_line_ff[0][k]  <= d5_ff[k];
         cr_line_ff[0][k] <= cr5_ff[k];
         e_line_ff[0][k]  <= e5_ff[k];
         for (int i = 1; i < GEO_DLY; i++) begin
            d_line_ff[i][k]  <= d_line_ff[i-1][k];
            cr_line_ff[i][k] <= cr_line_ff[i-1][k];
            e_line_ff[i][k]  <= e_line_ff[i-1][k];
         end
      end

      for (int k = 0; k < 3; k++) begin
         tc_ff[k]  <= 56'(d_line_ff[GEO_DLY-1][k]) * 56'(cos_q20);
         ts_ff[k]  <= 59'(cr_line_ff[GEO_DLY-1][k]) * 59'(sin_q20);
         to_ff[k]  <= 62'(e_line_ff[GEO_DLY-1][k]) * 62'(omc_q20);
         sum_ff[k] <= sum_in[k];
         res_ff[k] <= res_in[k];
      end
   end

   assign rsp_strobe         = valid_ff[OUT_LAT];
   assign rsp_data.rotated_x = res_ff[0];
   assign rsp_data.rotated_y = res_ff[1];
   assign rsp_data.rotated_z = res_ff[2];

endmodule
